>>> hw/rtl/dmc_pkg.sv
// dmc_pkg: shared types and the microprogram of the dot motion block.
// Holds the control word layout and the sequencer ROM.
// No dependencies.
package dmc_pkg;

	localparam int STEP_W = 5;

	// Test-point load
	typedef enum logic [1:0] {SET_NONE, SET_X, SET_Y} set_op_t;

	// Multiplier operand select
	typedef enum logic [2:0] {OP_DXB, OP_DYB, OP_DXO, OP_DYO, OP_RS} op_sel_t;

	// Accumulator operation
	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;

	// Position commit
	typedef enum logic [1:0] {CM_NONE, CM_X, CM_Y} commit_t;

	// Jump condition
	typedef enum logic {JMP_NONE, JMP_NOT_TICK} cond_t;

	typedef struct packed {
		set_op_t             set_op;
		op_sel_t             op_sel;
		acc_op_t             acc_op;
		logic                chk_box;
		commit_t             commit;
		logic                key;
		logic                last;
		cond_t               cond;
		logic [STEP_W-1:0]   target;
	} ctrl_word_t;

	// Datapath control group
	typedef struct packed {
		logic    en;
		op_sel_t op_sel;
		acc_op_t acc_op;
	} dp_ctrl_t;

	localparam logic [STEP_W-1:0] STEP_KEY = STEP_W'(16);

	// Microprogram: steps 0..7 test x, 8..15 test y, 16 handles keys
	function automatic ctrl_word_t prog_rom(input logic [STEP_W-1:0] step);
		ctrl_word_t cw;
		cw = '0;
		case (step)
			5'd0: begin
				cw.set_op = SET_X;
				cw.cond   = JMP_NOT_TICK;
				cw.target = STEP_KEY;
			end
			5'd1:  cw.op_sel = OP_DXB;
			5'd2:  cw.op_sel = OP_DYB;
			5'd3: begin
				cw.op_sel = OP_DXO;
				cw.acc_op = ACC_LOAD;
			end
			5'd4: begin
				cw.op_sel = OP_DYO;
				cw.acc_op = ACC_ADD;
			end
			5'd5: begin
				cw.op_sel  = OP_RS;
				cw.acc_op  = ACC_LOAD;
				cw.chk_box = 1'b1;
			end
			5'd6:  cw.acc_op = ACC_ADD;
			5'd7:  cw.commit = CM_X;
			5'd8:  cw.set_op = SET_Y;
			5'd9:  cw.op_sel = OP_DXB;
			5'd10: cw.op_sel = OP_DYB;
			5'd11: begin
				cw.op_sel = OP_DXO;
				cw.acc_op = ACC_LOAD;
			end
			5'd12: begin
				cw.op_sel = OP_DYO;
				cw.acc_op = ACC_ADD;
			end
			5'd13: begin
				cw.op_sel  = OP_RS;
				cw.acc_op  = ACC_LOAD;
				cw.chk_box = 1'b1;
			end
			5'd14: cw.acc_op = ACC_ADD;
			5'd15: begin
				cw.commit = CM_Y;
				cw.last   = 1'b1;
			end
			5'd16: begin
				cw.key  = 1'b1;
				cw.last = 1'b1;
			end
			default: cw.last = 1'b1;
		endcase
		return cw;
	endfunction

endpackage

>>> hw/rtl/dmc_dp.sv
// dmc_dp: squared-distance datapath with one shared multiplier.
// Operand register, product register and accumulator; driven by dp_ctrl_t.
// Depends on dmc_pkg.
module dmc_dp
	import dmc_pkg::*;
#(
	parameter int DOT_SIZE = 20
) (
	input  logic               clk,
	input  dp_ctrl_t           ctrl,
	input  logic signed [13:0] tx,
	input  logic signed [13:0] ty,
	input  logic [11:0]        box_x,
	input  logic [11:0]        box_y,
	input  logic [11:0]        box_w,
	input  logic [11:0]        box_h,
	input  logic [11:0]        obstacle_x,
	input  logic [11:0]        obstacle_y,
	input  logic [9:0]         obstacle_r,
	output logic               acc_lt_r2,
	output logic               acc_lt_prod
);

	localparam int          R    = DOT_SIZE / 2;
	localparam logic [31:0] R_SQ = 32'(R * R);

	logic signed [15:0] cx, cy, bxl, byl, bxh, byh, nx, ny;
	logic signed [15:0] dxb, dyb, dxo, dyo, rs, op_d;
	logic [12:0]        bxe, bye;
	logic signed [15:0] op_q;
	logic signed [31:0] sq;
	logic [31:0]        prod_q;
	logic [31:0]        acc_q;

	// Collider center and box edges
	assign cx  = $signed({{2{tx[13]}}, tx} + 16'(R));
	assign cy  = $signed({{2{ty[13]}}, ty} + 16'(R));
	assign bxe = {1'b0, box_x} + {1'b0, box_w};
	assign bye = {1'b0, box_y} + {1'b0, box_h};
	assign bxl = $signed({4'b0, box_x});
	assign byl = $signed({4'b0, box_y});
	assign bxh = $signed({3'b0, bxe});
	assign byh = $signed({3'b0, bye});

	// Nearest box point to the center
	always_comb begin
		if (cx < bxl) nx = bxl;
		else if (cx > bxh) nx = bxh;
		else nx = cx;
		if (cy < byl) ny = byl;
		else if (cy > byh) ny = byh;
		else ny = cy;
	end

	assign dxb = nx - cx;
	assign dyb = ny - cy;
	assign dxo = $signed({4'b0, obstacle_x}) - cx;
	assign dyo = $signed({4'b0, obstacle_y}) - cy;
	assign rs  = $signed({6'b0, obstacle_r} + 16'(R));

	// Operand select
	always_comb begin
		case (ctrl.op_sel)
			OP_DXB:  op_d = dxb;
			OP_DYB:  op_d = dyb;
			OP_DXO:  op_d = dxo;
			OP_DYO:  op_d = dyo;
			OP_RS:   op_d = rs;
			default: op_d = '0;
		endcase
	end

	// Full 32-bit square of the registered operand
	assign sq = op_q * op_q;

	// Operand, square and accumulate
	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			op_q   <= op_d;
			prod_q <= $unsigned(sq);
			case (ctrl.acc_op)
				ACC_LOAD: acc_q <= prod_q;
				ACC_ADD:  acc_q <= acc_q + prod_q;
				default:  acc_q <= acc_q;
			endcase
		end
	end

	assign acc_lt_r2   = acc_q < R_SQ;
	assign acc_lt_prod = acc_q < prod_q;

endmodule

>>> hw/rtl/dot_motion_with_collision.sv
// Dot motion with circular collider: velocity keys and collision-checked moves.
// Tick word: 16 microprogram steps, one per cycle; the result word is registered
// at the last step. Key or no-op word: step 0, then the key step 16.
// Next word accepted the cycle after the result is registered; a result left
// waiting holds the last step. Async active-low reset clears state, sequencer
// and output valid; screen 640 x 480.
module dot_motion_with_collision
	import dmc_pkg::*;
#(
	parameter int DOT_SIZE = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// fields from bit 0: direction[1:0], is_repeat[2], box_x[14:3], box_y[26:15],
	// box_w[38:27], box_h[50:39], obstacle_x[62:51], obstacle_y[74:63],
	// obstacle_r[84:75], zero fill[87:85]
	input  logic [87:0] s_tdata,
	// fields from bit 0: command[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// fields from bit 0: dot_x[11:0], dot_y[23:12], speed_x[27:24], speed_y[31:28],
	// blocked_x[32], blocked_y[33], zero fill[39:34]
	output logic [39:0] m_tdata
);

	localparam int DOT2 = 2 * (DOT_SIZE / 2);

	localparam logic [1:0] CMD_PRESS   = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_TICK    = 2'd2;
	localparam logic [1:0] DIR_UP      = 2'd0;
	localparam logic [1:0] DIR_DOWN    = 2'd1;
	localparam logic [1:0] DIR_RIGHT   = 2'd3;
	localparam logic       REG_SCREEN_W = 1'b0;

	localparam logic signed [3:0] VEL_MAX = 4'sd7;
	localparam logic signed [3:0] VEL_MIN = -4'sd7;

	// Saturating one-step velocity change
	function automatic logic signed [3:0] vel_step(input logic signed [3:0] v,
		input logic inc);
		logic signed [3:0] r;
		if (inc) r = (v == VEL_MAX) ? v : v + 4'sd1;
		else r = (v == VEL_MIN) ? v : v - 4'sd1;
		return r;
	endfunction

	logic [11:0]        scr_w_q, scr_h_q;
	logic               busy_q;
	logic [STEP_W-1:0]  step_q;
	logic [1:0]         cmd_q, dir_q;
	logic               rep_q;
	logic [11:0]        box_x_q, box_y_q, box_w_q, box_h_q, ob_x_q, ob_y_q;
	logic [9:0]         ob_r_q;
	logic [11:0]        pos_x_q, pos_y_q, pos_x_d, pos_y_d;
	logic signed [3:0]  vel_x_q, vel_y_q, vel_x_d, vel_y_d;
	logic               bx_q, by_q, bx_d, by_d;
	logic signed [13:0] tx_q, ty_q;
	logic               fail_q;
	logic               m_tvalid_q;
	logic [39:0]        m_tdata_q;

	ctrl_word_t         cw;
	dp_ctrl_t           dp_ctrl;
	logic               step_en, acc_lt_r2, acc_lt_prod;
	logic signed [14:0] tx_end, ty_end;
	logic               scr_fail_x, scr_fail_y, fail_x, fail_y;
	logic               key_inc, key_live;

	assign cw       = prog_rom(step_q);
	assign step_en  = busy_q && !(cw.last && m_tvalid_q && !m_tready);
	assign s_tready = !busy_q;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign dp_ctrl.en     = step_en;
	assign dp_ctrl.op_sel = cw.op_sel;
	assign dp_ctrl.acc_op = cw.acc_op;

	dmc_dp #(.DOT_SIZE(DOT_SIZE)) u_dp (
		.clk         (clk),
		.ctrl        (dp_ctrl),
		.tx          (tx_q),
		.ty          (ty_q),
		.box_x       (box_x_q),
		.box_y       (box_y_q),
		.box_w       (box_w_q),
		.box_h       (box_h_q),
		.obstacle_x  (ob_x_q),
		.obstacle_y  (ob_y_q),
		.obstacle_r  (ob_r_q),
		.acc_lt_r2   (acc_lt_r2),
		.acc_lt_prod (acc_lt_prod)
	);

	// Screen bound on the candidate corner, both axes for either move
	assign tx_end     = $signed({tx_q[13], tx_q} + 15'(DOT2));
	assign ty_end     = $signed({ty_q[13], ty_q} + 15'(DOT2));
	assign scr_fail_x = tx_q[13] || (tx_end > $signed({3'b0, scr_w_q}));
	assign scr_fail_y = ty_q[13] || (ty_end > $signed({3'b0, scr_h_q}));
	assign fail_x     = fail_q || acc_lt_prod || scr_fail_x || scr_fail_y;
	assign fail_y     = fail_q || acc_lt_prod || scr_fail_x || scr_fail_y;

	assign key_live = (cmd_q == CMD_PRESS || cmd_q == CMD_RELEASE) && !rep_q;
	assign key_inc  = (dir_q == DIR_DOWN || dir_q == DIR_RIGHT) ^ (cmd_q == CMD_RELEASE);

	// Next architectural state for this step
	always_comb begin
		pos_x_d = pos_x_q;
		pos_y_d = pos_y_q;
		vel_x_d = vel_x_q;
		vel_y_d = vel_y_q;
		bx_d    = bx_q;
		by_d    = by_q;
		case (cw.commit)
			CM_X: begin
				if (fail_x) bx_d = 1'b1;
				else pos_x_d = tx_q[11:0];
			end
			CM_Y: begin
				if (fail_y) by_d = 1'b1;
				else pos_y_d = ty_q[11:0];
			end
			default: ;
		endcase
		if (cw.key && key_live) begin
			if (dir_q == DIR_UP || dir_q == DIR_DOWN) vel_y_d = vel_step(vel_y_q, key_inc);
			else vel_x_d = vel_step(vel_x_q, key_inc);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= 12'd640;
			scr_h_q <= 12'd480;
		end else if (cfg_we) begin
			if (cfg_index == REG_SCREEN_W) scr_w_q <= cfg_data;
			else scr_h_q <= cfg_data;
		end
	end

	// Captured input word
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q   <= s_tuser;
			dir_q   <= s_tdata[1:0];
			rep_q   <= s_tdata[2];
			box_x_q <= s_tdata[14:3];
			box_y_q <= s_tdata[26:15];
			box_w_q <= s_tdata[38:27];
			box_h_q <= s_tdata[50:39];
			ob_x_q  <= s_tdata[62:51];
			ob_y_q  <= s_tdata[74:63];
			ob_r_q  <= s_tdata[84:75];
		end
	end

	// Test point and pending failure
	always_ff @(posedge clk) begin
		if (step_en) begin
			case (cw.set_op)
				SET_X: begin
					tx_q   <= $signed({2'b0, pos_x_q}) + {{10{vel_x_q[3]}}, vel_x_q};
					ty_q   <= $signed({2'b0, pos_y_q});
					fail_q <= 1'b0;
				end
				SET_Y: begin
					tx_q   <= $signed({2'b0, pos_x_q});
					ty_q   <= $signed({2'b0, pos_y_q}) + {{10{vel_y_q[3]}}, vel_y_q};
					fail_q <= 1'b0;
				end
				default: if (cw.chk_box) fail_q <= fail_q | acc_lt_r2;
			endcase
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (step_en && cw.last)
			m_tdata_q <= {6'b0, by_d, bx_d, vel_y_d, vel_x_d, pos_y_d, pos_x_d};
	end

	// Sequencer, state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			step_q     <= '0;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			vel_x_q    <= '0;
			vel_y_q    <= '0;
			bx_q       <= 1'b0;
			by_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (step_en && cw.last) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			if (s_tvalid && s_tready) begin
				busy_q <= 1'b1;
				step_q <= '0;
				bx_q   <= 1'b0;
				by_q   <= 1'b0;
			end else if (step_en) begin
				pos_x_q <= pos_x_d;
				pos_y_q <= pos_y_d;
				vel_x_q <= vel_x_d;
				vel_y_q <= vel_y_d;
				bx_q    <= bx_d;
				by_q    <= by_d;
				if (cw.last) begin
					busy_q <= 1'b0;
					step_q <= '0;
				end else if (cw.cond == JMP_NOT_TICK && cmd_q != CMD_TICK) begin
					step_q <= cw.target;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
		end
	end

	// Velocity never leaves the saturation range
	a_vel_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vel_x_q != 4'sh8) && (vel_y_q != 4'sh8))
		else $error("velocity outside saturation range");

	// Step counter stays inside the program
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_KEY)
		else $error("step counter beyond program");

	// Output valid rises only from a completed last step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(busy_q && cw.last))
		else $error("result word without finished program");

	// Key step never moves the sprite
	a_key_still: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && cw.key) |=> ($stable(pos_x_q) && $stable(pos_y_q)))
		else $error("key word moved position");

	// No new word is taken while the program runs
	a_busy_ready: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !s_tready)
		else $error("ready while busy");

endmodule
